// ----- hw/rtl/c_subset_tokenizer_core_defines.svh -----
// assertion macros used by the tokenizer core rtl
`ifndef C_SUBSET_TOKENIZER_CORE_DEFINES_SVH
`define C_SUBSET_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define CTOK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ctok_pkg.sv -----
// types, codes and lookup functions of the c subset tokenizer
package ctok_pkg;

    // result status codes
    localparam logic [1:0] ST_TOKEN = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // token kind codes
    localparam logic [4:0] K_ID     = 5'd0;
    localparam logic [4:0] K_INT    = 5'd1;
    localparam logic [4:0] K_CHAR   = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_KW0    = 5'd4;
    localparam logic [4:0] K_EQ     = 5'd13;
    localparam logic [4:0] K_AND    = 5'd14;
    localparam logic [4:0] K_OR     = 5'd15;
    localparam logic [4:0] K_PUNCT0 = 5'd16;
    localparam logic [4:0] K_ASSIGN = 5'd21;
    localparam logic [4:0] K_AMP    = 5'd24;
    localparam logic [4:0] K_SLASH  = 5'd29;

    localparam int PREFIX_BITS = 48;
    localparam int NUM_KW      = 9;
    localparam int NUM_PUNCT   = 15;

    // scanner modes
    typedef enum logic [15:0] {
        MODE_IDLE       = 16'h0001,
        MODE_SLASH      = 16'h0002,
        MODE_COMMENT    = 16'h0004,
        MODE_CMT_STAR   = 16'h0008,
        MODE_IDENT      = 16'h0010,
        MODE_ZERO       = 16'h0020,
        MODE_NUMBER     = 16'h0040,
        MODE_EQ         = 16'h0080,
        MODE_AMP        = 16'h0100,
        MODE_BAR        = 16'h0200,
        MODE_CH_OPEN    = 16'h0400,
        MODE_CH_ESC     = 16'h0800,
        MODE_CH_CLOSE   = 16'h1000,
        MODE_STR_BODY   = 16'h2000,
        MODE_STR_ESC    = 16'h4000,
        MODE_HALT       = 16'h8000
    } scan_mode_t;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  kind;
        logic [31:0] begin_off;
        logic [31:0] end_off;
        logic        last;
    } result_t;

    // keywords packed first character in the low byte
    localparam logic [PREFIX_BITS-1:0] KW_PACKED [NUM_KW] = '{
        48'h0000_7261_6863,   // char
        48'h0000_6573_6c65,   // else
        48'h0000_6f74_6f67,   // goto
        48'h0000_0000_6669,   // if
        48'h0000_0074_6e69,   // int
        48'h6e72_7574_6572,   // return
        48'h0000_6469_6f76,   // void
        48'h0065_6c69_6877,   // while
        48'h0000_676e_6f6c    // long
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd6, 3'd4, 3'd5, 3'd4
    };

    // single punctuators in kind order
    localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
        8'h3b, 8'h3a, 8'h7b, 8'h7d, 8'h2c, 8'h3d, 8'h28, 8'h29,
        8'h26, 8'h21, 8'h2d, 8'h2b, 8'h2a, 8'h2f, 8'h3c
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // identifier or keyword kind from the stored prefix and length
    function automatic logic [4:0] word_kind(input logic [PREFIX_BITS-1:0] prefix,
                                             input logic [2:0] len);
        logic [4:0] kind;
        kind = K_ID;
        for (int k = 0; k < NUM_KW; k++) begin
            if (prefix == KW_PACKED[k] && len == KW_LEN[k])
                kind = K_KW0 + 5'(k);
        end
        return kind;
    endfunction

    // punctuator lookup: hit flag above the kind code
    function automatic logic [5:0] punct_lookup(input logic [7:0] c);
        logic [5:0] hit;
        hit = '0;
        for (int i = 0; i < NUM_PUNCT; i++) begin
            if (c == PUNCT_CHARS[i])
                hit = {1'b1, K_PUNCT0 + 5'(i)};
        end
        return hit;
    endfunction

    function automatic result_t mk_result(input logic [1:0] status, input logic [4:0] kind,
                                          input logic [31:0] b, input logic [31:0] e);
        result_t r;
        r.status    = status;
        r.kind      = kind;
        r.begin_off = b;
        r.end_off   = e;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

// ----- hw/rtl/ctok_result_fifo.sv -----
// four-word result queue taking up to two words per cycle
module ctok_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_n,
    input  ctok_pkg::result_t  push_first,
    input  ctok_pkg::result_t  push_second,
    output logic               room_two,
    output logic               out_valid,
    input  logic               out_ready,
    output ctok_pkg::result_t  out_word
);
    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    ctok_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    logic [PTR_W-1:0]  tail_plus;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_word  = entry_reg[head_reg];
    assign room_two  = count_reg <= CNT_W'(DEPTH - 2);
    assign tail_plus = tail_reg + PTR_W'(1);

    // pointer and fill bookkeeping
    always_comb
    begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push_n);
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[tail_reg] <= push_first;
        if (push_n == 2'd2)
            entry_reg[tail_plus] <= push_second;
    end
endmodule

// ----- hw/rtl/c_subset_tokenizer_core.sv -----
// streaming c subset tokenizer: byte in, token words out
//
// channel | handshake            | payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | text_byte
// out     | out_valid / out_ready| result_status token_code begin_offset end_offset
//         |                      | last_of_run
//
// each byte is scanned in the cycle it is accepted; its words land in a four-deep
// result queue, so bytes go in one per cycle while the queue has room for two words.
// a byte that ends one token and emits another makes two words, and the output side
// drains one word per cycle, so the sustained rate is set by the output port.
// in_ready drops only when the queue holds three or more words.
// reset puts the scanner idle at offset zero; no clearing pass is needed.
`include "c_subset_tokenizer_core_defines.svh"

module c_subset_tokenizer_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_status,
    output logic [4:0]  token_code,
    output logic [31:0] begin_offset,
    output logic [31:0] end_offset,
    output logic        last_of_run
);
    localparam int PB = ctok_pkg::PREFIX_BITS;

    ctok_pkg::scan_mode_t   mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [PB-1:0]          prefix_reg, prefix_next;
    logic [2:0]             len_reg, len_next;

    logic                   in_fire;
    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] pos_plus;
    logic [31:0]            pos32, plus32, start32;
    logic                   redo, ended;
    logic                   a_vld, b_vld;
    ctok_pkg::result_t      res_a, res_b;
    logic [5:0]             punct_hit;
    logic [1:0]             push_n;
    ctok_pkg::result_t      push_first, push_second;
    ctok_pkg::result_t      out_word;
    logic                   room_two;

    assign in_ready  = room_two;
    assign in_fire   = in_valid && in_ready;
    assign c         = text_byte;
    assign pos_plus  = pos_reg + OFFSET_BITS'(1);
    assign pos32     = 32'(pos_reg);
    assign plus32    = 32'(pos_plus);
    assign start32   = 32'(start_reg);
    assign punct_hit = ctok_pkg::punct_lookup(c);

    // scanner step for the incoming byte
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        redo        = 1'b0;
        ended       = 1'b0;
        a_vld       = 1'b0;
        b_vld       = 1'b0;
        res_a       = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_ID, '0, '0);
        res_b       = res_a;

        // finish or extend the pending token
        unique case (mode_reg)
            ctok_pkg::MODE_IDLE: redo = 1'b1;
            ctok_pkg::MODE_SLASH:
            begin
                if (c == 8'h2a)
                    mode_next = ctok_pkg::MODE_COMMENT;
                else
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_SLASH,
                                                start32, pos32);
                    redo  = 1'b1;
                end
            end
            ctok_pkg::MODE_COMMENT:
            begin
                if (c == 8'h00)
                    redo = 1'b1;
                else if (c == 8'h2a)
                    mode_next = ctok_pkg::MODE_CMT_STAR;
            end
            ctok_pkg::MODE_CMT_STAR:
            begin
                if (c == 8'h00)
                    redo = 1'b1;
                else if (c == 8'h2f)
                    mode_next = ctok_pkg::MODE_IDLE;
                else if (c != 8'h2a)
                    mode_next = ctok_pkg::MODE_COMMENT;
            end
            ctok_pkg::MODE_IDENT:
            begin
                if (ctok_pkg::is_alpha(c) || ctok_pkg::is_digit(c))
                begin
                    if (len_reg < 3'd6)
                        prefix_next = prefix_reg | (PB'(c) << {len_reg, 3'b000});
                    if (len_reg < 3'd7)
                        len_next = len_reg + 3'd1;
                end
                else
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN,
                                                ctok_pkg::word_kind(prefix_reg, len_reg),
                                                start32, pos32);
                    redo  = 1'b1;
                end
            end
            ctok_pkg::MODE_ZERO:
            begin
                a_vld = 1'b1;
                res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_INT,
                                            start32, pos32);
                redo  = 1'b1;
            end
            ctok_pkg::MODE_NUMBER:
            begin
                if (!ctok_pkg::is_digit(c))
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_INT,
                                                start32, pos32);
                    redo  = 1'b1;
                end
            end
            ctok_pkg::MODE_EQ:
            begin
                a_vld = 1'b1;
                if (c == 8'h3d)
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_EQ,
                                                start32, plus32);
                    mode_next = ctok_pkg::MODE_IDLE;
                end
                else
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_ASSIGN,
                                                start32, pos32);
                    redo  = 1'b1;
                end
            end
            ctok_pkg::MODE_AMP:
            begin
                a_vld = 1'b1;
                if (c == 8'h26)
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_AND,
                                                start32, plus32);
                    mode_next = ctok_pkg::MODE_IDLE;
                end
                else
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_AMP,
                                                start32, pos32);
                    redo  = 1'b1;
                end
            end
            ctok_pkg::MODE_BAR:
            begin
                a_vld = 1'b1;
                if (c == 8'h7c)
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_OR,
                                                start32, plus32);
                    mode_next = ctok_pkg::MODE_IDLE;
                end
                else
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                start32, pos32);
                    mode_next = ctok_pkg::MODE_HALT;
                end
            end
            ctok_pkg::MODE_CH_OPEN:
            begin
                if (c == 8'h00 || c == 8'h27)
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                start32, pos32);
                    mode_next = ctok_pkg::MODE_HALT;
                end
                else if (c == 8'h5c)
                    mode_next = ctok_pkg::MODE_CH_ESC;
                else
                    mode_next = ctok_pkg::MODE_CH_CLOSE;
            end
            ctok_pkg::MODE_CH_ESC:
            begin
                if (c == 8'h6e || c == 8'h27 || c == 8'h5c)
                    mode_next = ctok_pkg::MODE_CH_CLOSE;
                else
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                start32, pos32);
                    mode_next = ctok_pkg::MODE_HALT;
                end
            end
            ctok_pkg::MODE_CH_CLOSE:
            begin
                a_vld = 1'b1;
                if (c == 8'h27)
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_CHAR,
                                                start32, plus32);
                    mode_next = ctok_pkg::MODE_IDLE;
                end
                else
                begin
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                start32, pos32);
                    mode_next = ctok_pkg::MODE_HALT;
                end
            end
            ctok_pkg::MODE_STR_BODY:
            begin
                if (c == 8'h00)
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                start32, pos32);
                    mode_next = ctok_pkg::MODE_HALT;
                end
                else if (c == 8'h22)
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, ctok_pkg::K_STRING,
                                                start32, plus32);
                    mode_next = ctok_pkg::MODE_IDLE;
                end
                else if (c == 8'h5c)
                    mode_next = ctok_pkg::MODE_STR_ESC;
            end
            ctok_pkg::MODE_STR_ESC:
            begin
                if (c == 8'h6e || c == 8'h22 || c == 8'h5c)
                    mode_next = ctok_pkg::MODE_STR_BODY;
                else
                begin
                    a_vld = 1'b1;
                    res_a = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                start32, pos32);
                    mode_next = ctok_pkg::MODE_HALT;
                end
            end
            default: mode_next = ctok_pkg::MODE_HALT;
        endcase

        // start a new token from this byte
        if (redo)
        begin
            mode_next  = ctok_pkg::MODE_IDLE;
            start_next = pos_reg;
            priority if (c == 8'h00)
            begin
                b_vld = 1'b1;
                res_b = ctok_pkg::mk_result(ctok_pkg::ST_END, ctok_pkg::K_ID, pos32, pos32);
                ended = 1'b1;
            end
            else if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d)
                mode_next = ctok_pkg::MODE_IDLE;
            else if (ctok_pkg::is_alpha(c))
            begin
                mode_next   = ctok_pkg::MODE_IDENT;
                prefix_next = PB'(c);
                len_next    = 3'd1;
            end
            else if (c == 8'h2f)
                mode_next = ctok_pkg::MODE_SLASH;
            else if (c == 8'h30)
                mode_next = ctok_pkg::MODE_ZERO;
            else if (c == 8'h27)
                mode_next = ctok_pkg::MODE_CH_OPEN;
            else if (c == 8'h22)
                mode_next = ctok_pkg::MODE_STR_BODY;
            else if (c == 8'h3d)
                mode_next = ctok_pkg::MODE_EQ;
            else if (c == 8'h26)
                mode_next = ctok_pkg::MODE_AMP;
            else if (c == 8'h7c)
                mode_next = ctok_pkg::MODE_BAR;
            else if (ctok_pkg::is_digit(c))
                mode_next = ctok_pkg::MODE_NUMBER;
            else if (punct_hit[5])
            begin
                b_vld = 1'b1;
                res_b = ctok_pkg::mk_result(ctok_pkg::ST_TOKEN, punct_hit[4:0], pos32, plus32);
            end
            else
            begin
                b_vld     = 1'b1;
                res_b     = ctok_pkg::mk_result(ctok_pkg::ST_ERROR, ctok_pkg::K_ID,
                                                pos32, pos32);
                mode_next = ctok_pkg::MODE_HALT;
            end
        end

        // byte offset advance, restart after end of text
        if (ended)
        begin
            mode_next = ctok_pkg::MODE_IDLE;
            pos_next  = '0;
        end
        else if (mode_next != ctok_pkg::MODE_HALT)
            pos_next = pos_plus;
    end

    // pack the words of this byte for the queue
    always_comb
    begin
        push_n      = in_fire ? 2'(a_vld) + 2'(b_vld) : 2'd0;
        push_first  = a_vld ? res_a : res_b;
        push_second = res_b;
        push_first.last  = !(a_vld && b_vld);
        push_second.last = 1'b1;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ctok_pkg::MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            prefix_reg <= '0;
            len_reg    <= '0;
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
        end
    end

    ctok_result_fifo u_result_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_n      (push_n),
        .push_first  (push_first),
        .push_second (push_second),
        .room_two    (room_two),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

    assign result_status = out_word.status;
    assign token_code    = out_word.kind;
    assign begin_offset  = out_word.begin_off;
    assign end_offset    = out_word.end_off;
    assign last_of_run   = out_word.last;

    // checks
    `CTOK_ASSERT_SAME(a_halt_silent, clk, rst_n,
        in_fire && mode_reg == ctok_pkg::MODE_HALT, push_n == 2'd0,
        "halted scanner produced a word")
    `CTOK_ASSERT_SAME(a_pair_last, clk, rst_n,
        push_n == 2'd2, !push_first.last && push_second.last,
        "two-word byte has wrong last flags")
    `CTOK_ASSERT_NEXT(a_end_restart, clk, rst_n,
        in_fire && ended, pos_reg == '0 && mode_reg == ctok_pkg::MODE_IDLE,
        "offset did not restart after end of text")
    `CTOK_ASSERT_NEXT(a_error_halts, clk, rst_n,
        push_n != 2'd0 && ((a_vld && res_a.status == ctok_pkg::ST_ERROR)
                           || (b_vld && res_b.status == ctok_pkg::ST_ERROR)),
        mode_reg == ctok_pkg::MODE_HALT,
        "error word without halt")
endmodule

// ----- sim/c_subset_tokenizer_core_checker.sv -----
// token word checker for the c subset tokenizer: predicts words from accepted bytes
`timescale 1ns / 1ps

module c_subset_tokenizer_core_checker
    import ctok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_status,
    input  logic [4:0]  token_code,
    input  logic [31:0] begin_offset,
    input  logic [31:0] end_offset,
    input  logic        last_of_run,
    output int          mismatches,
    output int          pending_words,
    output int          token_words,
    output int          end_words,
    output int          error_words
);

    localparam logic [4:0] KIND_NONE = 5'd0;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;

    // scanner copy
    scan_mode_t  mode;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [47:0] prefix;
    logic [2:0]  wlen;

    // words expected from the output, oldest first
    result_t expected_words [$];
    // words caused by the byte being scanned
    result_t run_words [$];

    function automatic logic lead_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic string keyword_text(input int k);
        case (k)
            0: return "char";
            1: return "else";
            2: return "goto";
            3: return "if";
            4: return "int";
            5: return "return";
            6: return "void";
            7: return "while";
            8: return "long";
            default: return "";
        endcase
    endfunction

    // keyword or plain identifier from the first six characters and the length
    function automatic logic [4:0] classify_word(input logic [47:0] pfx, input logic [2:0] n);
        string       s;
        logic [47:0] kw_bits;
        for (int k = 0; k < 9; k++)
        begin
            s = keyword_text(k);
            kw_bits = '0;
            for (int i = 0; i < s.len(); i++)
                kw_bits[8*i +: 8] = s[i];
            if (s.len() == int'(n) && kw_bits == pfx)
                return K_KW0 + 5'(k);
        end
        return K_ID;
    endfunction

    function automatic int punct_slot(input logic [7:0] c);
        string marks;
        marks = ";:{},=()&!-+*/<";
        for (int i = 0; i < marks.len(); i++)
            if (marks[i] == c)
                return i;
        return -1;
    endfunction

    task automatic emit(input logic [1:0] st, input logic [4:0] k,
                        input logic [31:0] b, input logic [31:0] e);
        result_t w;
        w.status    = st;
        w.kind      = k;
        w.begin_off = b;
        w.end_off   = e;
        w.last      = 1'b0;
        run_words.push_back(w);
    endtask

    task automatic raise_error(input logic [31:0] b, input logic [31:0] e);
        emit(ST_ERROR, KIND_NONE, b, e);
        mode = MODE_HALT;
    endtask

    // byte seen with no token pending
    task automatic start_fresh(input logic [7:0] c, output logic ended);
        int slot;
        ended = 1'b0;
        mode = MODE_IDLE;
        tok_start = pos;
        if (c == 8'h00)
        begin
            emit(ST_END, KIND_NONE, pos, pos);
            ended = 1'b1;
        end
        else if (c == " " || c == CH_TAB || c == CH_LF || c == CH_CR)
        begin
        end
        else if (lead_char(c))
        begin
            mode = MODE_IDENT;
            prefix = {40'd0, c};
            wlen = 3'd1;
        end
        else if (c == "/") mode = MODE_SLASH;
        else if (c == "0") mode = MODE_ZERO;
        else if (c == "'") mode = MODE_CH_OPEN;
        else if (c == "\"") mode = MODE_STR_BODY;
        else if (c == "=") mode = MODE_EQ;
        else if (c == "&") mode = MODE_AMP;
        else if (c == "|") mode = MODE_BAR;
        else if (digit_char(c)) mode = MODE_NUMBER;
        else
        begin
            slot = punct_slot(c);
            if (slot >= 0)
                emit(ST_TOKEN, K_PUNCT0 + 5'(slot), pos, pos + 32'd1);
            else
                raise_error(pos, pos);
        end
    endtask

    // scan one accepted byte and queue the words it causes
    task automatic lex_byte(input logic [7:0] c);
        logic [31:0] nxt;
        logic        redo;
        logic        ended;
        result_t     w;
        nxt = pos + 32'd1;
        redo = 1'b0;
        ended = 1'b0;
        run_words.delete();
        case (mode)
            MODE_IDLE: redo = 1'b1;
            MODE_SLASH:
            begin
                if (c == "*") mode = MODE_COMMENT;
                else
                begin
                    emit(ST_TOKEN, K_SLASH, tok_start, pos);
                    redo = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (c == 8'h00) redo = 1'b1;
                else if (c == "*") mode = MODE_CMT_STAR;
            end
            MODE_CMT_STAR:
            begin
                if (c == 8'h00) redo = 1'b1;
                else if (c == "/") mode = MODE_IDLE;
                else if (c != "*") mode = MODE_COMMENT;
            end
            MODE_IDENT:
            begin
                if (lead_char(c) || digit_char(c))
                begin
                    if (wlen < 3'd6)
                        prefix[8*wlen +: 8] = c;
                    if (wlen < 3'd7)
                        wlen = wlen + 3'd1;
                end
                else
                begin
                    emit(ST_TOKEN, classify_word(prefix, wlen), tok_start, pos);
                    redo = 1'b1;
                end
            end
            MODE_ZERO:
            begin
                emit(ST_TOKEN, K_INT, tok_start, pos);
                redo = 1'b1;
            end
            MODE_NUMBER:
            begin
                if (!digit_char(c))
                begin
                    emit(ST_TOKEN, K_INT, tok_start, pos);
                    redo = 1'b1;
                end
            end
            MODE_EQ:
            begin
                if (c == "=")
                begin
                    emit(ST_TOKEN, K_EQ, tok_start, nxt);
                    mode = MODE_IDLE;
                end
                else
                begin
                    emit(ST_TOKEN, K_ASSIGN, tok_start, pos);
                    redo = 1'b1;
                end
            end
            MODE_AMP:
            begin
                if (c == "&")
                begin
                    emit(ST_TOKEN, K_AND, tok_start, nxt);
                    mode = MODE_IDLE;
                end
                else
                begin
                    emit(ST_TOKEN, K_AMP, tok_start, pos);
                    redo = 1'b1;
                end
            end
            MODE_BAR:
            begin
                if (c == "|")
                begin
                    emit(ST_TOKEN, K_OR, tok_start, nxt);
                    mode = MODE_IDLE;
                end
                else raise_error(tok_start, pos);
            end
            MODE_CH_OPEN:
            begin
                if (c == 8'h00 || c == "'") raise_error(tok_start, pos);
                else if (c == "\\") mode = MODE_CH_ESC;
                else mode = MODE_CH_CLOSE;
            end
            MODE_CH_ESC:
            begin
                if (c == "n" || c == "'" || c == "\\") mode = MODE_CH_CLOSE;
                else raise_error(tok_start, pos);
            end
            MODE_CH_CLOSE:
            begin
                if (c == "'")
                begin
                    emit(ST_TOKEN, K_CHAR, tok_start, nxt);
                    mode = MODE_IDLE;
                end
                else raise_error(tok_start, pos);
            end
            MODE_STR_BODY:
            begin
                if (c == 8'h00) raise_error(tok_start, pos);
                else if (c == "\"")
                begin
                    emit(ST_TOKEN, K_STRING, tok_start, nxt);
                    mode = MODE_IDLE;
                end
                else if (c == "\\") mode = MODE_STR_ESC;
            end
            MODE_STR_ESC:
            begin
                if (c == "n" || c == "\"" || c == "\\") mode = MODE_STR_BODY;
                else raise_error(tok_start, pos);
            end
            default:
            begin
                // halted: nothing comes out until reset
                mode = MODE_HALT;
                return;
            end
        endcase

        if (redo)
            start_fresh(c, ended);

        // mark the final word of this byte
        if (run_words.size() > 0)
        begin
            w = run_words.pop_back();
            w.last = 1'b1;
            run_words.push_back(w);
        end
        foreach (run_words[i])
            expected_words.push_back(run_words[i]);

        if (ended)
        begin
            mode = MODE_IDLE;
            pos = '0;
        end
        else if (mode != MODE_HALT)
        begin
            pos = nxt;
        end
    endtask

    // compare one output word with the oldest expectation
    task automatic check_word();
        result_t want;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: unexpected word: expected none, got st=%0d kind=%0d ",
                          "beg=%0d end=%0d last=%0b"},
                         $time, result_status, token_code, begin_offset, end_offset,
                         last_of_run);
            return;
        end
        want = expected_words.pop_front();
        if (result_status == ST_TOKEN) token_words++;
        else if (result_status == ST_END) end_words++;
        else error_words++;
        if (want.status !== result_status || want.kind !== token_code ||
            want.begin_off !== begin_offset || want.end_off !== end_offset ||
            want.last !== last_of_run)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: word mismatch: expected st=%0d kind=%0d beg=%0d end=%0d ",
                          "last=%0b, got st=%0d kind=%0d beg=%0d end=%0d last=%0b"},
                         $time, want.status, want.kind, want.begin_off, want.end_off,
                         want.last, result_status, token_code, begin_offset, end_offset,
                         last_of_run);
        end
    endtask

    // watch both channels; bytes are scanned before words are compared
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode = MODE_IDLE;
            pos = '0;
            tok_start = '0;
            prefix = '0;
            wlen = '0;
            expected_words.delete();
            mismatches = 0;
            token_words = 0;
            end_words = 0;
            error_words = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                lex_byte(text_byte);
            if (out_valid && out_ready)
                check_word();
        end
        pending_words = expected_words.size();
    end

endmodule

// ----- sim/c_subset_tokenizer_core_tb.sv -----
// testbench top for the c subset tokenizer: source text stimulus, flow control and verdict
`timescale 1ns / 1ps

module c_subset_tokenizer_core_tb;
    import ctok_pkg::*;

    localparam int RANDOM_BYTES = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_status;
    logic [4:0]  token_code;
    logic [31:0] begin_offset;
    logic [31:0] end_offset;
    logic        last_of_run;

    int mismatches;
    int pending_words;
    int token_words;
    int end_words;
    int error_words;

    // source bytes to feed, built before reset is released
    logic [7:0] source_bytes [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    bit  hold_taken;

    c_subset_tokenizer_core #(
        .OFFSET_BITS(32)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_status(result_status),
        .token_code   (token_code),
        .begin_offset (begin_offset),
        .end_offset   (end_offset),
        .last_of_run  (last_of_run)
    );

    c_subset_tokenizer_core_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_status(result_status),
        .token_code   (token_code),
        .begin_offset (begin_offset),
        .end_offset   (end_offset),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .pending_words(pending_words),
        .token_words  (token_words),
        .end_words    (end_words),
        .error_words  (error_words)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("c_subset_tokenizer_core_tb: done, errors");
        $finish;
    end

    function automatic string keyword_text(input int k);
        case (k)
            0: return "char";
            1: return "else";
            2: return "goto";
            3: return "if";
            4: return "int";
            5: return "return";
            6: return "void";
            7: return "while";
            8: return "long";
            default: return "";
        endcase
    endfunction

    // letter or underscore
    function automatic logic [7:0] word_lead();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        return "_";
    endfunction

    // letter, underscore or digit
    function automatic logic [7:0] word_tail();
        int r;
        r = $urandom_range(0, 62);
        if (r < 53) return word_lead();
        return 8'h30 + 8'(r - 53);
    endfunction

    // nonzero byte other than the three given
    function automatic logic [7:0] byte_but(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] d);
        logic [7:0] v;
        do v = 8'($urandom_range(1, 255));
        while (v == a || v == b || v == d);
        return v;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            source_bytes.push_back(s[i]);
    endtask

    task automatic add_space();
        int r;
        repeat ($urandom_range(1, 3))
        begin
            r = $urandom_range(0, 3);
            source_bytes.push_back(r == 0 ? 8'h20 : r == 1 ? 8'h09 : r == 2 ? 8'h0a : 8'h0d);
        end
    endtask

    // identifiers, keywords and near-keywords, some long enough to saturate the length
    task automatic add_ident();
        string kw;
        int    n;
        kw = keyword_text($urandom_range(0, 8));
        case ($urandom_range(0, 3))
            0: push_text(kw);
            1:
            begin
                push_text(kw);
                repeat ($urandom_range(1, 3)) source_bytes.push_back(word_tail());
            end
            2: push_text(kw.substr(0, kw.len() - 2));
            default:
            begin
                n = $urandom_range(1, 10);
                source_bytes.push_back(word_lead());
                repeat (n - 1) source_bytes.push_back(word_tail());
            end
        endcase
    endtask

    task automatic add_number();
        if ($urandom_range(0, 2) == 0)
        begin
            source_bytes.push_back("0");
        end
        else
        begin
            source_bytes.push_back(8'h30 + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(0, 4)) source_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic add_char_lit();
        source_bytes.push_back("'");
        case ($urandom_range(0, 3))
            0: push_text("\\n");
            1: push_text("\\'");
            2: push_text("\\\\");
            default: source_bytes.push_back(byte_but("'", "\\", "'"));
        endcase
        source_bytes.push_back("'");
    endtask

    task automatic add_string();
        source_bytes.push_back("\"");
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 5))
                0: push_text("\\n");
                1: push_text("\\\"");
                2: push_text("\\\\");
                default: source_bytes.push_back(byte_but("\"", "\\", "\""));
            endcase
        end
        source_bytes.push_back("\"");
    endtask

    // block comment; an open one is left for the end of text to close
    task automatic add_comment(input bit closed);
        push_text("/*");
        if ($urandom_range(0, 3) == 0)
            source_bytes.push_back("/");
        repeat ($urandom_range(0, 10))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                source_bytes.push_back("*");
                source_bytes.push_back(byte_but("*", "/", "*"));
            end
            else
            begin
                source_bytes.push_back(byte_but("*", "*", "*"));
            end
        end
        if (closed)
        begin
            if ($urandom_range(0, 2) == 0)
                push_text("**/");
            else
                push_text("*/");
        end
    endtask

    // single punctuator; a slash is kept apart so it never opens a comment
    task automatic add_punct();
        string      marks;
        logic [7:0] c;
        marks = ";:{},=()&!-+*/<";
        c = marks[$urandom_range(0, 14)];
        source_bytes.push_back(c);
        if (c == "/")
            source_bytes.push_back(8'h20);
    endtask

    // one text of random well-formed tokens, ended by a zero byte
    task automatic add_text();
        int r;
        repeat ($urandom_range(0, 12))
        begin
            r = $urandom_range(0, 9);
            case (r)
                0, 1: add_ident();
                2: add_number();
                3: add_char_lit();
                4: add_string();
                5:
                begin
                    if ($urandom_range(0, 2) == 0)
                        push_text("==");
                    else if ($urandom_range(0, 1))
                        push_text("&&");
                    else
                        push_text("||");
                end
                6, 7: add_punct();
                8: add_comment(1'b1);
                default: add_space();
            endcase
            if ($urandom_range(0, 1))
                add_space();
        end
        if ($urandom_range(0, 7) == 0)
            add_comment(1'b0);
        source_bytes.push_back(8'h00);
    endtask

    // one lexical fault to end the run, then bytes that must be swallowed
    task automatic add_fault();
        string      odd;
        logic [7:0] v;
        odd = "#$%.>?@[]^~";
        case ($urandom_range(0, 5))
            0:
            begin
                // lone bar
                source_bytes.push_back("|");
                do v = 8'($urandom_range(0, 255)); while (v == "|");
                source_bytes.push_back(v);
            end
            1: push_text("''");
            2:
            begin
                // char literal never closed
                source_bytes.push_back("'");
                source_bytes.push_back(byte_but("'", "\\", "'"));
                do v = 8'($urandom_range(0, 255)); while (v == "'");
                source_bytes.push_back(v);
            end
            3:
            begin
                // unknown escape in a char or a string
                if ($urandom_range(0, 1))
                begin
                    push_text("'\\");
                    do v = 8'($urandom_range(0, 255)); while (v == "n" || v == "'" || v == "\\");
                end
                else
                begin
                    push_text("\"a\\");
                    do v = 8'($urandom_range(0, 255)); while (v == "n" || v == "\"" || v == "\\");
                end
                source_bytes.push_back(v);
            end
            4:
            begin
                // zero byte inside a literal
                if ($urandom_range(0, 1))
                    push_text("'");
                else
                    push_text("\"ab");
                source_bytes.push_back(8'h00);
            end
            default:
            begin
                // byte outside the lexical set
                add_ident();
                case ($urandom_range(0, 2))
                    0: v = 8'($urandom_range(128, 255));
                    1: v = odd[$urandom_range(0, odd.len() - 1)];
                    default: v = 8'($urandom_range(1, 8));
                endcase
                source_bytes.push_back(v);
            end
        endcase
        repeat ($urandom_range(3, 6)) source_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // output side: random stalls plus one long hold
    initial
    begin
        out_ready = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // build the text, reset, feed the bytes, wait for the words, verdict
    initial
    begin
        int third;
        int base;
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = 8'h00;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;

        // short directed text: zero alone, number into char, escapes, operators, lone slash
        push_text("a0 0 9'\\n'\"\\\"\"==&&||/ *;");
        source_bytes.push_back(8'h00);
        base = source_bytes.size();
        while (source_bytes.size() < base + RANDOM_BYTES)
            add_text();
        add_fault();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        third = source_bytes.size() / 3;
        foreach (source_bytes[i])
        begin
            if (i < third)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 85;
            end
            else if (i < 2 * third)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req = 1'b1;
            end
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            text_byte <= source_bytes[i];
            do @(posedge clk); while (!in_ready);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_words != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d bytes, %0d texts ended, %0d tokens, %0d error word(s)",
                 source_bytes.size(), end_words, token_words, error_words);
        $display("flow: slow receiver, slow sender, full rate, one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_words == 0)
            $display("c_subset_tokenizer_core_tb: done, clean");
        else
            $display("c_subset_tokenizer_core_tb: done, errors");
        $finish;
    end

endmodule
